>>> rtl/lpmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpmc_pkg
// Shared types and constants of the lidar point mask classifier.
// ----------------------------------------------------------------------------
package lpmc_pkg;

  localparam int CW      = 37;
  localparam int PW      = 35;
  localparam int NW      = 51;
  localparam int QW      = 11;
  localparam int DIV_LAT = QW + 1;
  localparam int MASK_AW = 20;
  localparam int QDEPTH  = 32;

  localparam int IMAGE_WIDTH_DEF  = 640;
  localparam int IMAGE_HEIGHT_DEF = 480;

  localparam logic [2:0] CFG_ROW_DEPTH  = 3'd0;
  localparam logic [2:0] CFG_ROW_HORIZ  = 3'd1;
  localparam logic [2:0] CFG_ROW_VERT   = 3'd2;
  localparam logic [2:0] CFG_FOCAL      = 3'd3;
  localparam logic [2:0] CFG_CENTER_U   = 3'd4;
  localparam logic [2:0] CFG_CENTER_V   = 3'd5;
  localparam logic [2:0] CFG_MIN_DEPTH  = 3'd6;

  localparam logic OP_MASK_WRITE = 1'b0;
  localparam logic OP_POINT      = 1'b1;

  localparam logic [1:0] CLASS_DROPPED  = 2'd0;
  localparam logic [1:0] CLASS_OBSTACLE = 2'd1;
  localparam logic [1:0] CLASS_ROAD     = 2'd2;

  localparam int FLAG_ROAD = 0;
  localparam int FLAG_OBST = 1;

  typedef struct packed {
    logic [63:0] row_d;
    logic [63:0] row_h;
    logic [63:0] row_v;
    logic [11:0] focal;
    logic [9:0]  cu;
    logic [9:0]  cv;
    logic [15:0] min_depth;
  } cfg_t;

  typedef struct packed {
    logic                op;
    logic                wr_ok;
    logic [1:0]          flags;
    logic [MASK_AW-1:0]  addr;
    logic signed [18:0]  x;
    logic signed [18:0]  y;
    logic signed [18:0]  z;
  } tag_t;

  typedef struct packed {
    logic                op;
    logic                wr_ok;
    logic                keep;
    logic [1:0]          flags;
    logic [MASK_AW-1:0]  addr;
    logic [9:0]          u;
    logic [8:0]          v;
    logic signed [18:0]  x;
    logic signed [18:0]  y;
    logic signed [18:0]  z;
  } qent_t;

endpackage

>>> rtl/lpmc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpmc_div
// Pipelined restoring divider producing a short quotient and an overflow flag.
// ----------------------------------------------------------------------------
module lpmc_div import lpmc_pkg::*; (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [NW-1:0] den,
  output logic [QW-1:0] quo,
  output logic          ovf
);

  logic [NW-1:0] rem_r [0:QW];
  logic [NW-1:0] den_r [0:QW];
  logic [QW-1:0] q_r   [0:QW];
  logic          ovf_r [0:QW];

  always_ff @(posedge clk) begin
    rem_r[0] <= num;
    den_r[0] <= den;
    q_r[0]   <= '0;
    ovf_r[0] <= (num >= (den << QW));
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    localparam int B = QW - k;
    logic [NW-1:0] sh;
    logic          ge;
    assign sh = den_r[k-1] << B;
    assign ge = (rem_r[k-1] >= sh);
    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? (rem_r[k-1] - sh) : rem_r[k-1];
      den_r[k] <= den_r[k-1];
      q_r[k]   <= q_r[k-1] | (QW'(ge) << B);
      ovf_r[k] <= ovf_r[k-1];
    end
  end

  assign quo = q_r[QW];
  assign ovf = ovf_r[QW];

endmodule

>>> rtl/lpmc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpmc_front
// Transforms and projects points, and carries mask writes along in order.
// ----------------------------------------------------------------------------
module lpmc_front import lpmc_pkg::*; #(
  parameter int IMAGE_WIDTH  = IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = IMAGE_HEIGHT_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  in_valid,
  input  tag_t  in_tag,
  output logic  out_valid,
  output qent_t out_ent
);

  logic [63:0]             rows [3];
  logic signed [CW-1:0]    tr   [3];
  logic signed [18:0]      axis [3];
  logic signed [CW-1:0]    mind;

  logic [4:0]              v_r;
  tag_t                    tag_r [5];
  logic signed [PW-1:0]    p_r [3][3];
  logic signed [CW-1:0]    c_r [3];
  logic signed [CW-1:0]    d4_r;
  logic                    deep4_r;
  logic signed [NW-1:0]    fh_r, cud_r, fw_r, cvd_r;
  logic signed [NW-1:0]    nu, nv;
  logic [NW-1:0]           abs_u_r, abs_v_r, den5_r;
  logic                    neg_u_r, neg_v_r, deep5_r;

  logic [DIV_LAT-1:0]      dv_r;
  tag_t                    dtag_r  [DIV_LAT];
  logic                    ddeep_r [DIV_LAT];
  logic                    dnu_r   [DIV_LAT];
  logic                    dnv_r   [DIV_LAT];
  logic [QW-1:0]           qu, qv;
  logic                    ovu, ovv;
  logic                    ok_u, ok_v, keep;
  logic                    out_valid_r;
  qent_t                   out_ent_r;

  assign rows = '{cfg.row_d, cfg.row_h, cfg.row_v};
  assign axis = '{tag_r[0].x, tag_r[0].y, tag_r[0].z};
  for (genvar r = 0; r < 3; r++) begin : g_tr
    assign tr[r] = {{(CW - 30){rows[r][63]}}, rows[r][63:48], 14'b0};
  end
  assign mind = {{(CW - 31){1'b0}}, 1'b0, cfg.min_depth, 14'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      dv_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v_r  <= {v_r[3:0], in_valid};
      dv_r <= {dv_r[DIV_LAT-2:0], v_r[4]};
      out_valid_r <= dv_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    tag_r[0] <= in_tag;
    for (int s = 1; s < 5; s++) begin
      tag_r[s] <= tag_r[s-1];
    end
    for (int r = 0; r < 3; r++) begin
      for (int a = 0; a < 3; a++) begin
        p_r[r][a] <= PW'($signed(rows[r][16*a +: 16])) * PW'(axis[a]);
      end
      c_r[r] <= CW'(p_r[r][0]) + CW'(p_r[r][1]) + CW'(p_r[r][2]) + tr[r];
    end
    d4_r    <= c_r[0];
    deep4_r <= (c_r[0] > mind);
    fh_r    <= NW'($signed({1'b0, cfg.focal})) * NW'(c_r[1]);
    fw_r    <= NW'($signed({1'b0, cfg.focal})) * NW'(c_r[2]);
    cud_r   <= NW'($signed({1'b0, cfg.cu})) * NW'(c_r[0]);
    cvd_r   <= NW'($signed({1'b0, cfg.cv})) * NW'(c_r[0]);
    neg_u_r <= nu[NW-1];
    neg_v_r <= nv[NW-1];
    abs_u_r <= nu[NW-1] ? NW'(-nu) : NW'(nu);
    abs_v_r <= nv[NW-1] ? NW'(-nv) : NW'(nv);
    den5_r  <= {{(NW - CW){1'b0}}, d4_r};
    deep5_r <= deep4_r;
  end

  assign nu = fh_r + cud_r;
  assign nv = fw_r + cvd_r;

  lpmc_div u_div_u (.clk(clk), .num(abs_u_r), .den(den5_r), .quo(qu), .ovf(ovu));
  lpmc_div u_div_v (.clk(clk), .num(abs_v_r), .den(den5_r), .quo(qv), .ovf(ovv));

  always_ff @(posedge clk) begin
    dtag_r[0]  <= tag_r[4];
    ddeep_r[0] <= deep5_r;
    dnu_r[0]   <= neg_u_r;
    dnv_r[0]   <= neg_v_r;
    for (int s = 1; s < DIV_LAT; s++) begin
      dtag_r[s]  <= dtag_r[s-1];
      ddeep_r[s] <= ddeep_r[s-1];
      dnu_r[s]   <= dnu_r[s-1];
      dnv_r[s]   <= dnv_r[s-1];
    end
  end

  assign ok_u = !ovu && (dnu_r[DIV_LAT-1] ? (qu == '0) : (32'(qu) < IMAGE_WIDTH));
  assign ok_v = !ovv && (dnv_r[DIV_LAT-1] ? (qv == '0) : (32'(qv) < IMAGE_HEIGHT));
  assign keep = ddeep_r[DIV_LAT-1] && ok_u && ok_v;

  always_ff @(posedge clk) begin
    out_ent_r.op    <= dtag_r[DIV_LAT-1].op;
    out_ent_r.wr_ok <= dtag_r[DIV_LAT-1].wr_ok;
    out_ent_r.flags <= dtag_r[DIV_LAT-1].flags;
    out_ent_r.x     <= dtag_r[DIV_LAT-1].x;
    out_ent_r.y     <= dtag_r[DIV_LAT-1].y;
    out_ent_r.z     <= dtag_r[DIV_LAT-1].z;
    out_ent_r.keep  <= keep;
    out_ent_r.u     <= keep ? qu[9:0] : 10'd0;
    out_ent_r.v     <= keep ? qv[8:0] : 9'd0;
    if (dtag_r[DIV_LAT-1].op == OP_MASK_WRITE) begin
      out_ent_r.addr <= dtag_r[DIV_LAT-1].addr;
    end else begin
      out_ent_r.addr <= MASK_AW'(32'(qv) * 32'(IMAGE_WIDTH) + 32'(qu));
    end
  end

  assign out_valid = out_valid_r;
  assign out_ent   = out_ent_r;

endmodule

>>> rtl/lpmc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpmc_queue
// Small first-in first-out queue between the front and back sections.
// ----------------------------------------------------------------------------
module lpmc_queue import lpmc_pkg::*; #(
  parameter int DEPTH = QDEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t push_data,
  input  logic  pop,
  output qent_t head,
  output logic  empty
);

  localparam int PTRW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  qent_t           mem_r [DEPTH];
  logic [PTRW-1:0] wp_r, rp_r;
  logic [CNTW-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (32'(wp_r) == DEPTH - 1) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (32'(rp_r) == DEPTH - 1) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + CNTW'(push) - CNTW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  assign head  = mem_r[rp_r];
  assign empty = (cnt_r == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> 32'(cnt_r) < DEPTH) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("queue underflow");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 1'b1) else $error("queue count");

endmodule

>>> rtl/lpmc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpmc_back
// Applies mask writes, looks up point flags and drives the result channel.
// ----------------------------------------------------------------------------
module lpmc_back import lpmc_pkg::*; #(
  parameter int IMAGE_WIDTH  = IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = IMAGE_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  qent_t              q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_point_class,
  output logic [9:0]         out_image_u,
  output logic [8:0]         out_image_v,
  output logic signed [18:0] out_x,
  output logic signed [18:0] out_y,
  output logic signed [18:0] out_z
);

  localparam int MDEPTH = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int AW     = $clog2(MDEPTH);

  logic [1:0]  mask_mem [MDEPTH];
  logic [1:0]  rd_r;
  logic        b1_v_r, b1_v_nxt;
  qent_t       b1_r;
  logic        b1_move;
  logic        out_v_r, out_v_nxt;
  logic [1:0]  cls;

  assign b1_move = b1_v_r && (!out_v_r || out_ready);
  assign q_pop   = !q_empty && (!b1_v_r || b1_move);

  always_comb begin
    b1_v_nxt = b1_v_r;
    if (b1_move) begin
      b1_v_nxt = 1'b0;
    end
    if (q_pop && q_head.op == OP_POINT) begin
      b1_v_nxt = 1'b1;
    end
    out_v_nxt = out_v_r;
    if (out_ready) begin
      out_v_nxt = 1'b0;
    end
    if (b1_move) begin
      out_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      b1_v_r  <= b1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.op == OP_MASK_WRITE && q_head.wr_ok) begin
      mask_mem[q_head.addr[AW-1:0]] <= q_head.flags;
    end
    if (q_pop && q_head.op == OP_POINT) begin
      rd_r <= mask_mem[q_head.addr[AW-1:0]];
      b1_r <= q_head;
    end
  end

  always_comb begin
    cls = CLASS_DROPPED;
    if (b1_r.keep) begin
      if (rd_r[FLAG_OBST]) begin
        cls = CLASS_OBSTACLE;
      end else if (rd_r[FLAG_ROAD]) begin
        cls = CLASS_ROAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b1_move) begin
      out_point_class <= cls;
      out_image_u     <= b1_r.u;
      out_image_v     <= b1_r.v;
      out_x           <= b1_r.x;
      out_y           <= b1_r.y;
      out_z           <= b1_r.z;
    end
  end

  assign out_valid = out_v_r;

endmodule

>>> rtl/lidar_point_mask_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_point_mask_classifier
// Classifies lidar points against a per-pixel road and obstacle mask.
// ----------------------------------------------------------------------------
// The input channel carries two kinds of request: a mask write (in_op low)
// stores the road and obstacle flags of one pixel, and a point (in_op high)
// is transformed, projected and looked up in the mask. Each point yields one
// result on the output channel; mask writes yield none. Results leave in the
// order their requests arrived, and writes take effect in that order too.
// One request is accepted per clock while in_ready is high. A point passes
// through the transform multipliers, the two 12-stage pipelined dividers
// and the mask memory read on its way to out_valid.
// A 32-entry queue sits between the projection pipeline and the mask stage;
// in_ready drops once 32 requests are in flight, so a stalled receiver
// backs up into the input channel without losing anything.
// Reset loads the default calibration and empties the pipeline. The mask is
// not cleared: every pixel must be written before a point reads it. The user
// writes configuration via cfg_wr_en only while idle, unenforced by the block.
// ----------------------------------------------------------------------------
module lidar_point_mask_classifier import lpmc_pkg::*; #(
  parameter int IMAGE_WIDTH  = IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = IMAGE_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic [9:0]         in_pixel_u,
  input  logic [8:0]         in_pixel_v,
  input  logic [7:0]         in_mask_blue,
  input  logic [7:0]         in_mask_green,
  input  logic signed [18:0] in_point_x,
  input  logic signed [18:0] in_point_y,
  input  logic signed [18:0] in_point_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_point_class,
  output logic [9:0]         out_image_u,
  output logic [8:0]         out_image_v,
  output logic signed [18:0] out_x,
  output logic signed [18:0] out_y,
  output logic signed [18:0] out_z
);

  localparam int OW = $clog2(QDEPTH + 1);

  cfg_t          cfg_r;
  tag_t          in_tag;
  logic          in_acc;
  logic          f_valid;
  qent_t         f_ent;
  logic          q_pop, q_empty;
  qent_t         q_head;
  logic [OW-1:0] occ_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_d     <= 64'd16384;
      cfg_r.row_h     <= 64'd3221225472;
      cfg_r.row_v     <= 64'd211106232532992;
      cfg_r.focal     <= 12'd320;
      cfg_r.cu        <= 10'd320;
      cfg_r.cv        <= 10'd240;
      cfg_r.min_depth <= 16'd100;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ROW_DEPTH: cfg_r.row_d     <= cfg_data;
        CFG_ROW_HORIZ: cfg_r.row_h     <= cfg_data;
        CFG_ROW_VERT:  cfg_r.row_v     <= cfg_data;
        CFG_FOCAL:     cfg_r.focal     <= cfg_data[11:0];
        CFG_CENTER_U:  cfg_r.cu        <= cfg_data[9:0];
        CFG_CENTER_V:  cfg_r.cv        <= cfg_data[9:0];
        CFG_MIN_DEPTH: cfg_r.min_depth <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign in_ready = (occ_r < OW'(QDEPTH));
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_r + OW'(in_acc) - OW'(q_pop);
    end
  end

  assign in_tag.op    = in_op;
  assign in_tag.wr_ok = (32'(in_pixel_u) < IMAGE_WIDTH) && (32'(in_pixel_v) < IMAGE_HEIGHT);
  assign in_tag.flags = {in_mask_green > 8'd127, in_mask_blue > 8'd127};
  assign in_tag.addr  = MASK_AW'(32'(in_pixel_v) * 32'(IMAGE_WIDTH) + 32'(in_pixel_u));
  assign in_tag.x     = in_point_x;
  assign in_tag.y     = in_point_y;
  assign in_tag.z     = in_point_z;

  lpmc_front #(
    .IMAGE_WIDTH (IMAGE_WIDTH),
    .IMAGE_HEIGHT(IMAGE_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_acc),
    .in_tag   (in_tag),
    .out_valid(f_valid),
    .out_ent  (f_ent)
  );

  lpmc_queue #(
    .DEPTH(QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f_valid),
    .push_data(f_ent),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  lpmc_back #(
    .IMAGE_WIDTH (IMAGE_WIDTH),
    .IMAGE_HEIGHT(IMAGE_HEIGHT)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_point_class(out_point_class),
    .out_image_u    (out_image_u),
    .out_image_v    (out_image_v),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_z          (out_z)
  );

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the lidar point mask classifier.
// ----------------------------------------------------------------------------
// Mask writes and points go in over the request channel in random bursts
// while the result side stalls on its own pattern. A behavioral copy of the
// transform, projection and mask lookup predicts every point's class and
// pixel, and each result is compared field by field in arrival order.
// Several calibrations are loaded, the reset one, swapped axes, perturbed,
// random and extreme rows among them. Before any point that would land on an
// unwritten pixel, that pixel is written first.
// ----------------------------------------------------------------------------
module testbench;
  import lpmc_pkg::*;

  localparam int IMG_W = 640;
  localparam int IMG_H = 480;
  localparam int SETTLE_CYCLES = 40;
  localparam int LIMIT_CYCLES = 2000000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [1:0]  cls;
    logic [9:0]  u;
    logic [8:0]  v;
    logic [18:0] x;
    logic [18:0] y;
    logic [18:0] z;
  } point_res_t;

  class point_result_board;
    point_res_t pending[$];
    int errors;

    function void note_request(point_res_t r);
      pending = {pending, r};
    endfunction

    function void check_result(point_res_t r);
      point_res_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Result with no request waiting: class %0d u %0d v %0d",
                                   r.cls, r.u, r.v);
        return;
      end
      e = pending.pop_front();
      if (e.cls !== r.cls || e.u !== r.u || e.v !== r.v ||
          e.x !== r.x || e.y !== r.y || e.z !== r.z) begin
        errors++;
        if (errors <= 10) begin
          $display("Mismatch exp cls %0d u %0d v %0d x %h y %h z %h", e.cls, e.u, e.v,
                   e.x, e.y, e.z);
          $display("         got cls %0d u %0d v %0d x %h y %h z %h", r.cls, r.u, r.v,
                   r.x, r.y, r.z);
        end
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [2:0]        cfg_index = CFG_ROW_DEPTH;
  logic [63:0]       cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_op = OP_MASK_WRITE;
  logic [9:0]        in_pixel_u = '0;
  logic [8:0]        in_pixel_v = '0;
  logic [7:0]        in_mask_blue = '0;
  logic [7:0]        in_mask_green = '0;
  logic [18:0]       in_point_x = '0;
  logic [18:0]       in_point_y = '0;
  logic [18:0]       in_point_z = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_point_class;
  logic [9:0]        out_image_u;
  logic [8:0]        out_image_v;
  logic signed [18:0] out_x;
  logic signed [18:0] out_y;
  logic signed [18:0] out_z;

  lidar_point_mask_classifier u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_pixel_u(in_pixel_u), .in_pixel_v(in_pixel_v),
    .in_mask_blue(in_mask_blue), .in_mask_green(in_mask_green),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .out_valid(out_valid), .out_ready(out_ready), .out_point_class(out_point_class),
    .out_image_u(out_image_u), .out_image_v(out_image_v),
    .out_x(out_x), .out_y(out_y), .out_z(out_z)
  );

  always #10 clk = ~clk;

  point_result_board board = new();

  logic [63:0] cal_row_d = 64'd16384;
  logic [63:0] cal_row_h = 64'd3221225472;
  logic [63:0] cal_row_v = 64'd211106232532992;
  logic [11:0] cal_focal = 12'd320;
  logic [9:0]  cal_cu = 10'd320;
  logic [9:0]  cal_cv = 10'd240;
  logic [15:0] cal_min_depth = 16'd100;
  logic [1:0]  mask_mem [0:IMG_W*IMG_H-1];
  bit          mask_written [0:IMG_W*IMG_H-1];

  int  cycle_count = 0;
  bit  hold_request = 1'b0;
  int  fwd_axis = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_result('{out_point_class, out_image_u, out_image_v, out_x, out_y, out_z});
  end

  initial begin
    int hold_left;
    int mode;
    int mode_age;
    hold_left = 0;
    mode = 0;
    mode_age = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        mode_age++;
        if (mode_age >= 150) begin
          mode_age = 0;
          mode = $urandom_range(0, 2);
        end
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  function automatic longint row_eval(logic [63:0] row, longint x, longint y, longint z);
    longint wx = longint'($signed(row[15:0]));
    longint wy = longint'($signed(row[31:16]));
    longint wz = longint'($signed(row[47:32]));
    longint t = longint'($signed(row[63:48]));
    return wx * x + wy * y + wz * z + t * 16384;
  endfunction

  // Pixel index hit by a point, or -1 when dropped for depth or off-image.
  function automatic int project_point(logic [18:0] px, logic [18:0] py, logic [18:0] pz,
                                       output logic [9:0] pu, output logic [8:0] pv);
    longint x = longint'($signed(px));
    longint y = longint'($signed(py));
    longint z = longint'($signed(pz));
    longint d;
    longint h;
    longint w;
    longint u;
    longint v;
    pu = '0;
    pv = '0;
    d = row_eval(cal_row_d, x, y, z);
    if (d <= longint'(cal_min_depth) * 16384) return -1;
    h = row_eval(cal_row_h, x, y, z);
    w = row_eval(cal_row_v, x, y, z);
    u = (longint'(cal_focal) * h + longint'(cal_cu) * d) / d;
    v = (longint'(cal_focal) * w + longint'(cal_cv) * d) / d;
    if (u < 0 || u >= IMG_W || v < 0 || v >= IMG_H) return -1;
    pu = u[9:0];
    pv = v[8:0];
    return int'(v) * IMG_W + int'(u);
  endfunction

  task automatic send_request(logic op, logic [9:0] pu, logic [8:0] pv, logic [7:0] blue,
                              logic [7:0] green, logic [18:0] x, logic [18:0] y,
                              logic [18:0] z);
    point_res_t r;
    int idx;
    logic [9:0] iu;
    logic [8:0] iv;
    in_valid <= 1'b1;
    in_op <= op;
    in_pixel_u <= pu;
    in_pixel_v <= pv;
    in_mask_blue <= blue;
    in_mask_green <= green;
    in_point_x <= x;
    in_point_y <= y;
    in_point_z <= z;
    do @(posedge clk); while (!in_ready);
    if (op == OP_MASK_WRITE) begin
      if (pu < IMG_W && pv < IMG_H) begin
        mask_mem[pv * IMG_W + pu] = {green > 8'd127, blue > 8'd127};
        mask_written[pv * IMG_W + pu] = 1'b1;
      end
    end else begin
      idx = project_point(x, y, z, iu, iv);
      r = '{CLASS_DROPPED, iu, iv, x, y, z};
      if (idx >= 0) begin
        if (mask_mem[idx][FLAG_OBST]) r.cls = CLASS_OBSTACLE;
        else if (mask_mem[idx][FLAG_ROAD]) r.cls = CLASS_ROAD;
      end
      board.note_request(r);
    end
  endtask

  task automatic send_point(logic [18:0] x, logic [18:0] y, logic [18:0] z);
    int idx;
    logic [9:0] iu;
    logic [8:0] iv;
    idx = project_point(x, y, z, iu, iv);
    if (idx >= 0 && !mask_written[idx])
      send_request(OP_MASK_WRITE, iu, iv, 8'($urandom), 8'($urandom), '0, '0, '0);
    send_request(OP_POINT, '0, '0, '0, '0, x, y, z);
  endtask

  task automatic send_mask(logic [9:0] pu, logic [8:0] pv, logic [7:0] blue,
                           logic [7:0] green);
    send_request(OP_MASK_WRITE, pu, pv, blue, green, 19'($urandom), 19'($urandom),
                 19'($urandom));
  endtask

  task automatic pause_sender(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_ROW_DEPTH: cal_row_d = data;
      CFG_ROW_HORIZ: cal_row_h = data;
      CFG_ROW_VERT:  cal_row_v = data;
      CFG_FOCAL:     cal_focal = data[11:0];
      CFG_CENTER_U:  cal_cu = data[9:0];
      CFG_CENTER_V:  cal_cv = data[9:0];
      default:       cal_min_depth = data[15:0];
    endcase
  endtask

  task automatic load_calibration(logic [63:0] rd, logic [63:0] rh, logic [63:0] rv,
                                  logic [63:0] f, logic [63:0] cu, logic [63:0] cv,
                                  logic [63:0] md);
    write_reg(CFG_ROW_DEPTH, rd);
    write_reg(CFG_ROW_HORIZ, rh);
    write_reg(CFG_ROW_VERT, rv);
    write_reg(CFG_FOCAL, f);
    write_reg(CFG_CENTER_U, cu);
    write_reg(CFG_CENTER_V, cv);
    write_reg(CFG_MIN_DEPTH, md);
  endtask

  function automatic logic [63:0] pack_row(int wx, int wy, int wz, int t);
    logic [15:0] a = wx[15:0];
    logic [15:0] b = wy[15:0];
    logic [15:0] c = wz[15:0];
    logic [15:0] e = t[15:0];
    return {e, c, b, a};
  endfunction

  function automatic logic [18:0] lateral(int span);
    int s = $urandom_range(0, 2 * span);
    return 19'(s - span);
  endfunction

  task automatic send_random_item;
    logic [18:0] p [3];
    int span;
    int fwd;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 20) begin
      if ($urandom_range(0, 4) == 0)
        send_mask(10'($urandom), 9'($urandom), 8'($urandom), 8'($urandom));
      else send_mask(10'($urandom_range(0, IMG_W - 1)), 9'($urandom_range(0, IMG_H - 1)),
                     8'($urandom), 8'($urandom));
    end else if (sel < 30) begin
      send_point(19'($urandom), 19'($urandom), 19'($urandom));
    end else begin
      case ($urandom_range(0, 3))
        0: span = 500;
        1: span = 5000;
        2: span = 60000;
        default: span = 262143;
      endcase
      fwd = $urandom_range(1, span);
      p[0] = lateral(fwd);
      p[1] = lateral(fwd);
      p[2] = lateral(fwd);
      p[fwd_axis] = 19'(fwd);
      send_point(p[0], p[1], p[2]);
    end
  endtask

  task automatic run_random(int n);
    int sent;
    int burst;
    bit steady;
    sent = 0;
    steady = 1'($urandom_range(0, 1));
    while (sent < n) begin
      burst = $urandom_range(1, 24);
      repeat (burst) send_random_item();
      sent += burst;
      if (!steady && $urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
      if ($urandom_range(0, 9) == 0) steady = ~steady;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_mask(10'd0, 9'd0, 8'd0, 8'd128);
    send_mask(10'd639, 9'd479, 8'd128, 8'd127);
    send_mask(10'd320, 9'd240, 8'd255, 8'd255);
    send_mask(10'd330, 9'd250, 8'd127, 8'd127);
    send_mask(10'd1023, 9'd511, 8'd255, 8'd255);
    send_mask(10'd640, 9'd0, 8'd0, 8'd0);
    send_mask(10'd0, 9'd480, 8'd0, 8'd0);
    send_point(19'd1000, 19'd0, 19'd0);
    send_point(19'd1000, 19'd1000, 19'd1000);
    send_point(19'd320, -19'sd319, -19'sd239);
    send_point(19'd320, -19'sd10, -19'sd10);
    send_point(19'd100, 19'd0, 19'd0);
    send_point(19'd101, 19'd0, 19'd0);
    send_point(-19'sd5000, 19'd0, 19'd0);
    send_point(19'd320, -19'sd320, 19'd0);
    send_point(19'd3200, 19'd3205, 19'd3205);
    send_point(19'd262143, -19'sd262144, 19'd262143);
    send_point(-19'sd262144, 19'd262143, -19'sd262144);
    send_point(19'd262143, 19'd0, 19'd0);
    drain();

    run_random(150);
    hold_request = 1'b1;
    repeat (80) send_random_item();
    drain();
    run_random(100);
    drain();

    fwd_axis = 1;
    load_calibration(pack_row(0, 16384, 0, 0), pack_row(16384, 0, 0, 256),
                     pack_row(0, 0, -16384, -50), 64'd4095, 64'd1023, 64'd0, 64'd0);
    run_random(150);
    drain();

    fwd_axis = 0;
    load_calibration(pack_row(16384 - $urandom_range(0, 512), $urandom_range(0, 1024) - 512,
                              $urandom_range(0, 1024) - 512, $urandom_range(0, 400) - 200),
                     pack_row($urandom_range(0, 1024) - 512, -16384,
                              $urandom_range(0, 1024) - 512, $urandom_range(0, 400) - 200),
                     pack_row($urandom_range(0, 1024) - 512, $urandom_range(0, 1024) - 512,
                              -16384, $urandom_range(0, 400) - 200),
                     {$urandom, 20'($urandom), 12'($urandom_range(100, 800))},
                     {$urandom, 22'($urandom), 10'($urandom_range(200, 440))},
                     {$urandom, 22'($urandom), 10'($urandom_range(150, 330))},
                     {$urandom, 16'($urandom), 16'($urandom_range(0, 500))});
    run_random(200);
    drain();

    load_calibration(64'd16384, 64'd3221225472, 64'd211106232532992,
                     64'd0, 64'd320, 64'd240, 64'd100);
    run_random(60);
    drain();
    write_reg(CFG_FOCAL, 64'd1);
    run_random(40);
    drain();

    load_calibration(64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'h7FFF_7FFF_7FFF_7FFF,
                     64'd4095, 64'd0, 64'd1023, 64'd65535);
    run_random(30);
    drain();
    write_reg(CFG_ROW_DEPTH, 64'd0);
    write_reg(CFG_MIN_DEPTH, 64'd0);
    run_random(15);
    drain();

    fwd_axis = $urandom_range(0, 2);
    load_calibration({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                     64'($urandom_range(1, 4095)), 64'($urandom_range(0, 1023)),
                     64'($urandom_range(0, 1023)), 64'($urandom_range(0, 65535)));
    run_random(150);
    drain();

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/lpmc_pkg.sv
rtl/lpmc_div.sv
rtl/lpmc_front.sv
rtl/lpmc_queue.sv
rtl/lpmc_back.sv
rtl/lidar_point_mask_classifier.sv
dv/testbench.sv
